>>> hw/rtl/vndi_pkg.sv
// vndi_pkg: shared constants and types for the vertex/normal dedup indexer
// used by vndi_cell and vertex_normal_dedup_indexer_unit, no dependencies
`default_nettype none

package vndi_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int WORD_W              = 32;
   localparam int TRIPLE_W            = 3 * WORD_W;
   localparam int INDEX_OUT_W         = 8;

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [TRIPLE_W-1:0] triple_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

endpackage : vndi_pkg

`default_nettype wire

>>> hw/rtl/vertex_normal_dedup_indexer_unit.sv
// vertex_normal_dedup_indexer_unit: top level, holds the row of cells
// depends on vndi_pkg and vndi_cell
// a request is searched in ST_SEARCH while the match result ripples through
//   the row of cells, one cell per cycle; ST_DECIDE then registers the
//   response once rsp is free; a new request is taken only in ST_IDLE
// reset: entry count cleared, stored entries undefined, no clearing pass
`default_nettype none

module vertex_normal_dedup_indexer_unit #(
   parameter int TABLE_DEPTH = vndi_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire vndi_pkg::word_type              req_vert_x,
   input  wire vndi_pkg::word_type              req_vert_y,
   input  wire vndi_pkg::word_type              req_vert_z,
   input  wire vndi_pkg::word_type              req_norm_x,
   input  wire vndi_pkg::word_type              req_norm_y,
   input  wire vndi_pkg::word_type              req_norm_z,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [vndi_pkg::INDEX_OUT_W-1:0]     rsp_mesh_index,
   output logic                                 rsp_is_new,
   output logic                                 rsp_overflow
);
   import vndi_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         step_ff, step_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   triple_type               vert_key_ff, norm_key_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_OUT_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                     rsp_new_ff, rsp_new_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     req_fire;
   logic                     rsp_free;
   logic                     hit;
   logic                     full;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_index;
   logic [IDX_W+INDEX_OUT_W-1:0] hit_ext;
   logic [IDX_W+INDEX_OUT_W-1:0] new_ext;

   logic             vfound_chain [0:TABLE_DEPTH];
   logic [IDX_W-1:0] vidx_chain   [0:TABLE_DEPTH];
   logic             nfound_chain [0:TABLE_DEPTH];
   logic [IDX_W-1:0] nidx_chain   [0:TABLE_DEPTH];

   assign vfound_chain[0] = 1'b0;
   assign vidx_chain[0]   = '0;
   assign nfound_chain[0] = 1'b0;
   assign nidx_chain[0]   = '0;

   assign wr_index = count_ff[IDX_W-1:0];

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      vndi_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .CELL_INDEX  (g)
      ) u_cell (
         .clock      (clock),
         .vert_key   (vert_key_ff),
         .norm_key   (norm_key_ff),
         .count      (count_ff),
         .wr_en      (wr_en),
         .wr_index   (wr_index),
         .vfound_in  (vfound_chain[g]),
         .vidx_in    (vidx_chain[g]),
         .nfound_in  (nfound_chain[g]),
         .nidx_in    (nidx_chain[g]),
         .vfound_out (vfound_chain[g+1]),
         .vidx_out   (vidx_chain[g+1]),
         .nfound_out (nfound_chain[g+1]),
         .nidx_out   (nidx_chain[g+1])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign hit  = vfound_chain[TABLE_DEPTH] && nfound_chain[TABLE_DEPTH] &&
                 (vidx_chain[TABLE_DEPTH] == nidx_chain[TABLE_DEPTH]);
   assign full = (count_ff == FULL_CNT);

   assign hit_ext = {{INDEX_OUT_W{1'b0}}, vidx_chain[TABLE_DEPTH]};
   assign new_ext = {{INDEX_OUT_W{1'b0}}, wr_index};

   assign wr_en = (state_ff == ST_DECIDE) && rsp_free && !hit && !full;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               step_in  = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               priority if (hit) begin
                  rsp_index_in = hit_ext[INDEX_OUT_W-1:0];
                  rsp_new_in   = 1'b0;
                  rsp_ovf_in   = 1'b0;
               end else if (!full) begin
                  rsp_index_in = new_ext[INDEX_OUT_W-1:0];
                  rsp_new_in   = 1'b1;
                  rsp_ovf_in   = 1'b0;
                  count_in     = count_ff + 1'b1;
               end else begin
                  rsp_index_in = '0;
                  rsp_new_in   = 1'b0;
                  rsp_ovf_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         vert_key_ff <= {req_vert_z, req_vert_y, req_vert_x};
         norm_key_ff <= {req_norm_z, req_norm_y, req_norm_x};
      end
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mesh_index = rsp_index_ff;
   assign rsp_is_new     = rsp_new_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule : vertex_normal_dedup_indexer_unit

`default_nettype wire

>>> hw/rtl/vndi_cell.sv
// vndi_cell: one table entry (vertex and normal) with its match logic and a
// registered stage of the highest-match chain; depends on vndi_pkg
`default_nettype none

module vndi_cell #(
   parameter int TABLE_DEPTH = vndi_pkg::DEFAULT_TABLE_DEPTH,
   parameter int CELL_INDEX  = 0,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  wire                        clock,
   input  wire vndi_pkg::triple_type  vert_key,
   input  wire vndi_pkg::triple_type  norm_key,
   input  wire  [CNT_W-1:0]           count,
   input  wire                        wr_en,
   input  wire  [IDX_W-1:0]           wr_index,
   input  wire                        vfound_in,
   input  wire  [IDX_W-1:0]           vidx_in,
   input  wire                        nfound_in,
   input  wire  [IDX_W-1:0]           nidx_in,
   output logic                       vfound_out,
   output logic [IDX_W-1:0]           vidx_out,
   output logic                       nfound_out,
   output logic [IDX_W-1:0]           nidx_out
);
   import vndi_pkg::*;

   localparam logic [IDX_W-1:0] CELL_SEL = IDX_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] CELL_POS = CNT_W'(CELL_INDEX);

   triple_type       vert_ff;
   triple_type       norm_ff;
   logic             vfound_ff;
   logic [IDX_W-1:0] vidx_ff;
   logic             nfound_ff;
   logic [IDX_W-1:0] nidx_ff;

   logic             occupied;
   logic             vmatch;
   logic             nmatch;
   logic             vfound_in_w;
   logic [IDX_W-1:0] vidx_in_w;
   logic             nfound_in_w;
   logic [IDX_W-1:0] nidx_in_w;

   assign occupied = (CELL_POS < count);
   assign vmatch   = occupied && (vert_ff == vert_key);
   assign nmatch   = occupied && (norm_ff == norm_key);

   // a higher cell overrides whatever came from below
   assign vfound_in_w = vmatch | vfound_in;
   assign vidx_in_w   = vmatch ? CELL_SEL : vidx_in;
   assign nfound_in_w = nmatch | nfound_in;
   assign nidx_in_w   = nmatch ? CELL_SEL : nidx_in;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_index == CELL_SEL)) begin
         vert_ff <= vert_key;
         norm_ff <= norm_key;
      end
      vfound_ff <= vfound_in_w;
      vidx_ff   <= vidx_in_w;
      nfound_ff <= nfound_in_w;
      nidx_ff   <= nidx_in_w;
   end

   assign vfound_out = vfound_ff;
   assign vidx_out   = vidx_ff;
   assign nfound_out = nfound_ff;
   assign nidx_out   = nidx_ff;

endmodule : vndi_cell

`default_nettype wire
